// File: design/session_heartbeat_monitor_core_assert.svh
// assertion macros for the heartbeat monitor
`ifndef SESSION_HEARTBEAT_MONITOR_CORE_ASSERT_SVH
`define SESSION_HEARTBEAT_MONITOR_CORE_ASSERT_SVH

// generic clocked property, disabled in reset
`define SHM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same-cycle implication
`define SHM_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/shm_pkg.sv
`default_nettype none
package shm_pkg;

  localparam int SESSIONS    = 64;
  localparam int TIME_BITS   = 32;
  localparam int MAX_RESULTS = 64;

  localparam int IDX_W  = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
  localparam int SLOT_W = 6;
  localparam int ID_W   = 32;
  localparam int IVL_W  = 32;
  localparam int CMP_W  = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int WORD_W = 2 * TIME_BITS + IVL_W;

  typedef enum logic [1:0] {
    K_OPEN  = 2'd0,
    K_BEAT  = 2'd1,
    K_TICK  = 2'd2,
    K_CLOSE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    RK_REPLY      = 3'd0,
    RK_HDR_REJ    = 3'd1,
    RK_VAL_REJ    = 3'd2,
    RK_TEST_REQ   = 3'd3,
    RK_DISCONNECT = 3'd4
  } result_kind_t;

endpackage
`default_nettype wire

// File: design/shm_ram.sv
`default_nettype none
module shm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [ADDR_W-1:0]     waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic                  re,
  input  wire logic [ADDR_W-1:0]     raddr,
  output      logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: design/session_heartbeat_monitor_core.sv
// open and close take effect in the cycle they are accepted, no result
// heartbeat: table read, then S_HB loads the result when the output is free, then idle
// tick: per session slot a table read (S_T_RD), then evaluate and write back (S_T_EV),
//   then S_T_END releases the final result, if any; held longer if results stall
// reset (rst, synchronous) clears active and pending flags; table words stay as they are
`default_nettype none
`include "session_heartbeat_monitor_core_assert.svh"
module session_heartbeat_monitor_core
  import shm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [1:0]        kind,
  input  wire logic [SLOT_W-1:0] client,
  input  wire logic [31:0]       now,
  input  wire logic [IVL_W-1:0]  interval,
  input  wire logic              header_ok,
  input  wire logic [ID_W-1:0]   test_req_id,
  input  wire logic [31:0]       seq_num,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [2:0]        result_kind,
  output      logic [SLOT_W-1:0] slot,
  output      logic [ID_W-1:0]   test_id,
  output      logic [31:0]       ref_seq,
  output      logic              last
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HB    = 5'b00010,
    S_T_RD  = 5'b00100,
    S_T_EV  = 5'b01000,
    S_T_END = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [SESSIONS-1:0] act, act_next;
  logic [SESSIONS-1:0] tp, tp_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [CNT_W-1:0]    cnt, cnt_next;

  // item held across the multi-cycle work
  logic [TIME_BITS-1:0] now_q;
  logic                 hdr_q;
  logic [ID_W-1:0]      treq_q;
  logic [31:0]          seq_q;

  // tick result held back until the next one shows whether it is the final one
  logic              hold_valid, hold_valid_next;
  logic [2:0]        hold_kind, hold_kind_next;
  logic [IDX_W-1:0]  hold_slot, hold_slot_next;
  logic [ID_W-1:0]   hold_tid, hold_tid_next;

  logic              out_load;
  logic              out_valid_next;
  logic [2:0]        result_kind_next;
  logic [SLOT_W-1:0] slot_next;
  logic [ID_W-1:0]   test_id_next;
  logic [31:0]       ref_seq_next;
  logic              last_next;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic [TIME_BITS-1:0] rd_seen, rd_pid, elapsed;
  logic [IVL_W-1:0]     rd_ivl;
  logic                 in_fire, out_free, slot_ok, expired, fire, walk_done;
  logic [IDX_W-1:0]     item_slot;
  logic                 msg_kind, drop_fire;

  // word layout: last_seen, beat_interval, pending_id
  assign rd_pid  = ram_rdata[TIME_BITS-1:0];
  assign rd_ivl  = ram_rdata[TIME_BITS +: IVL_W];
  assign rd_seen = ram_rdata[WORD_W-1 -: TIME_BITS];
  assign elapsed = now_q - rd_seen;
  assign expired = CMP_W'(elapsed) > CMP_W'(rd_ivl);
  assign fire    = act[idx] && expired;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign item_slot = IDX_W'(client);
  assign slot_ok   = 32'(client) < 32'(SESSIONS);
  assign walk_done = (idx == IDX_W'(SESSIONS - 1)) ||
                     (fire && (cnt == CNT_W'(MAX_RESULTS - 1)));

  assign msg_kind  = (result_kind == RK_REPLY) || (result_kind == RK_HDR_REJ) ||
                     (result_kind == RK_VAL_REJ);
  assign drop_fire = (state == S_T_EV) && fire && tp[idx] && !(hold_valid && !out_free);

  shm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SESSIONS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next       = state;
    act_next         = act;
    tp_next          = tp;
    idx_next         = idx;
    cnt_next         = cnt;
    hold_valid_next  = hold_valid;
    hold_kind_next   = hold_kind;
    hold_slot_next   = hold_slot;
    hold_tid_next    = hold_tid;
    out_load         = 1'b0;
    result_kind_next = result_kind;
    slot_next        = slot;
    test_id_next     = test_id;
    ref_seq_next     = ref_seq;
    last_next        = last;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_waddr        = idx;
    ram_raddr        = idx;
    ram_wdata        = {now_q, rd_ivl, rd_pid};

    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          idx_next = item_slot;
          unique case (kind)
            K_OPEN: begin
              if (slot_ok) begin
                act_next[item_slot] = 1'b1;
                tp_next[item_slot]  = 1'b0;
                ram_we    = 1'b1;
                ram_waddr = item_slot;
                ram_wdata = {TIME_BITS'(now), interval, {TIME_BITS{1'b0}}};
              end
            end
            K_CLOSE: begin
              if (slot_ok) begin
                act_next[item_slot] = 1'b0;
                tp_next[item_slot]  = 1'b0;
              end
            end
            K_BEAT: begin
              if (slot_ok && act[item_slot]) begin
                ram_re     = 1'b1;
                ram_raddr  = item_slot;
                state_next = S_HB;
              end
            end
            K_TICK: begin
              idx_next        = '0;
              cnt_next        = '0;
              hold_valid_next = 1'b0;
              state_next      = S_T_RD;
            end
            default: ;
          endcase
        end
      end

      S_HB: begin
        if (out_free) begin
          out_load     = 1'b1;
          slot_next    = SLOT_W'(idx);
          test_id_next = '0;
          last_next    = 1'b1;
          if (!hdr_q) begin
            result_kind_next = RK_HDR_REJ;
            ref_seq_next     = seq_q;
          end else if (tp[idx] && (CMP_W'(rd_pid) != CMP_W'(treq_q))) begin
            result_kind_next = RK_VAL_REJ;
            ref_seq_next     = seq_q;
          end else begin
            result_kind_next = RK_REPLY;
            ref_seq_next     = '0;
            tp_next[idx]     = 1'b0;
            ram_we           = 1'b1;
            ram_wdata        = {now_q, rd_ivl, rd_pid};
          end
          state_next = S_IDLE;
        end
      end

      S_T_RD: begin
        ram_re     = 1'b1;
        state_next = S_T_EV;
      end

      S_T_EV: begin
        if (!(fire && hold_valid && !out_free)) begin
          if (fire) begin
            if (hold_valid) begin
              out_load         = 1'b1;
              result_kind_next = hold_kind;
              slot_next        = SLOT_W'(hold_slot);
              test_id_next     = hold_tid;
              ref_seq_next     = '0;
              last_next        = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_slot_next  = idx;
            if (tp[idx]) begin
              hold_kind_next = RK_DISCONNECT;
              hold_tid_next  = '0;
              act_next[idx]  = 1'b0;
              tp_next[idx]   = 1'b0;
            end else begin
              hold_kind_next = RK_TEST_REQ;
              hold_tid_next  = ID_W'(now_q);
              tp_next[idx]   = 1'b1;
              ram_we         = 1'b1;
              ram_wdata      = {now_q, rd_ivl, now_q};
            end
            cnt_next = cnt + 1'b1;
          end
          if (walk_done) begin
            state_next = S_T_END;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_T_RD;
          end
        end
      end

      S_T_END: begin
        if (!hold_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          out_load         = 1'b1;
          result_kind_next = hold_kind;
          slot_next        = SLOT_W'(hold_slot);
          test_id_next     = hold_tid;
          ref_seq_next     = '0;
          last_next        = 1'b1;
          hold_valid_next  = 1'b0;
          state_next       = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    out_valid_next = out_load || (out_valid && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      act        <= '0;
      tp         <= '0;
      idx        <= '0;
      cnt        <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      act        <= act_next;
      tp         <= tp_next;
      idx        <= idx_next;
      cnt        <= cnt_next;
      hold_valid <= hold_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      now_q  <= TIME_BITS'(now);
      hdr_q  <= header_ok;
      treq_q <= test_req_id;
      seq_q  <= seq_num;
    end
    hold_kind   <= hold_kind_next;
    hold_slot   <= hold_slot_next;
    hold_tid    <= hold_tid_next;
    result_kind <= result_kind_next;
    slot        <= slot_next;
    test_id     <= test_id_next;
    ref_seq     <= ref_seq_next;
    last        <= last_next;
  end

  `SHM_IMPLY(a_out_no_overwrite, out_load, !out_valid || out_ready, "result overwritten")
  `SHM_IMPLY(a_hold_empty_idle, state == S_IDLE, !hold_valid, "held tick result left behind")
  `SHM_IMPLY(a_msg_result_last, out_valid && msg_kind, last, "message result not final")
  `SHM_ASSERT(a_drop_clears, drop_fire |=> !act[$past(idx)], "dropped session still active")

endmodule
`default_nettype wire

// File: tb/sv/shm_checker.sv
`timescale 1ns / 100ps
module shm_checker
  import shm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        kind,
  input  logic [SLOT_W-1:0] client,
  input  logic [31:0]       now,
  input  logic [IVL_W-1:0]  interval,
  input  logic              header_ok,
  input  logic [ID_W-1:0]   test_req_id,
  input  logic [31:0]       seq_num,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [2:0]        result_kind,
  input  logic [SLOT_W-1:0] slot,
  input  logic [ID_W-1:0]   test_id,
  input  logic [31:0]       ref_seq,
  input  logic              last,
  output int                errors,
  output int                waiting
);

  typedef struct packed {
    result_kind_t      kind;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   test_id;
    logic [31:0]       ref_seq;
    logic              last;
  } session_msg_t;

  logic        live [SESSIONS];
  logic [31:0] seen_at [SESSIONS];
  logic [31:0] beat_ivl [SESSIONS];
  logic        test_open [SESSIONS];
  logic [31:0] test_tag [SESSIONS];

  session_msg_t due_msgs [$];
  int           mismatches = 0;

  task automatic push_msg(input result_kind_t k, input logic [SLOT_W-1:0] s,
                          input logic [31:0] tid, input logic [31:0] rs);
    session_msg_t m;
    m.kind    = k;
    m.slot    = s;
    m.test_id = tid;
    m.ref_seq = rs;
    m.last    = 1'b0;
    due_msgs.push_back(m);
  endtask

  // advance the session table by one event and queue the messages it owes
  task automatic run_session_event(input logic [1:0] k, input logic [SLOT_W-1:0] c,
                                   input logic [31:0] t, input logic [31:0] ivl,
                                   input logic hok, input logic [31:0] treq,
                                   input logic [31:0] sq);
    int           first;
    int           i;
    logic [31:0]  elapsed;
    session_msg_t m;
    first = due_msgs.size();
    if (k == K_TICK) begin
      for (i = 0; i < SESSIONS; i++) begin
        elapsed = t - seen_at[i];
        if (live[i] && elapsed > beat_ivl[i]) begin
          if (!test_open[i]) begin
            seen_at[i]   = t;
            test_open[i] = 1'b1;
            test_tag[i]  = t;
            push_msg(RK_TEST_REQ, i[SLOT_W-1:0], t, 32'd0);
          end else begin
            live[i]      = 1'b0;
            test_open[i] = 1'b0;
            push_msg(RK_DISCONNECT, i[SLOT_W-1:0], 32'd0, 32'd0);
          end
        end
      end
    end else if (c < SESSIONS) begin
      if (k == K_OPEN) begin
        live[c]      = 1'b1;
        seen_at[c]   = t;
        beat_ivl[c]  = ivl;
        test_open[c] = 1'b0;
        test_tag[c]  = 32'd0;
      end else if (k == K_CLOSE) begin
        live[c]      = 1'b0;
        test_open[c] = 1'b0;
      end else if (live[c]) begin
        if (!hok) begin
          push_msg(RK_HDR_REJ, c, 32'd0, sq);
        end else if (test_open[c] && test_tag[c] != treq) begin
          push_msg(RK_VAL_REJ, c, 32'd0, sq);
        end else begin
          test_open[c] = 1'b0;
          seen_at[c]   = t;
          push_msg(RK_REPLY, c, 32'd0, 32'd0);
        end
      end
    end
    if (due_msgs.size() > first) begin
      m = due_msgs.pop_back();
      m.last = 1'b1;
      due_msgs.push_back(m);
    end
  endtask

  task automatic check_msg();
    session_msg_t m;
    if (due_msgs.size() == 0) begin
      mismatches++;
      $display("%0t: result with nothing due: kind %0d slot %0d test_id %h ref_seq %h last %0d",
               $time, result_kind, slot, test_id, ref_seq, last);
    end else begin
      m = due_msgs.pop_front();
      if (result_kind !== m.kind) begin
        mismatches++;
        $display("%0t: result_kind expected %0d, actual %0d", $time, m.kind, result_kind);
      end
      if (slot !== m.slot) begin
        mismatches++;
        $display("%0t: slot expected %0d, actual %0d", $time, m.slot, slot);
      end
      if (test_id !== m.test_id) begin
        mismatches++;
        $display("%0t: test_id expected %h, actual %h", $time, m.test_id, test_id);
      end
      if (ref_seq !== m.ref_seq) begin
        mismatches++;
        $display("%0t: ref_seq expected %h, actual %h", $time, m.ref_seq, ref_seq);
      end
      if (last !== m.last) begin
        mismatches++;
        $display("%0t: last expected %0d, actual %0d", $time, m.last, last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SESSIONS; i++) begin
        live[i]      = 1'b0;
        test_open[i] = 1'b0;
      end
      due_msgs.delete();
    end else begin
      if (in_valid && in_ready)
        run_session_event(kind, client, now, interval, header_ok, test_req_id, seq_num);
      if (out_valid && out_ready)
        check_msg();
    end
    waiting <= due_msgs.size();
    errors  <= mismatches;
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
module tb;
  import shm_pkg::*;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [1:0]        kind        = K_OPEN;
  logic [SLOT_W-1:0] client      = '0;
  logic [31:0]       now         = '0;
  logic [IVL_W-1:0]  interval    = '0;
  logic              header_ok   = 1'b0;
  logic [ID_W-1:0]   test_req_id = '0;
  logic [31:0]       seq_num     = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [2:0]        result_kind;
  logic [SLOT_W-1:0] slot;
  logic [ID_W-1:0]   test_id;
  logic [31:0]       ref_seq;
  logic              last;
  int                errors;
  int                waiting;

  int          idle_pct  = 0;
  int          stall_pct = 0;
  logic [31:0] cur_time;
  logic [31:0] tick_hist [4];
  int          tick_wp   = 0;

  always #5 clk = ~clk;

  session_heartbeat_monitor_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .client(client), .now(now), .interval(interval),
    .header_ok(header_ok), .test_req_id(test_req_id), .seq_num(seq_num),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .slot(slot), .test_id(test_id),
    .ref_seq(ref_seq), .last(last)
  );

  shm_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .client(client), .now(now), .interval(interval),
    .header_ok(header_ok), .test_req_id(test_req_id), .seq_num(seq_num),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .slot(slot), .test_id(test_id),
    .ref_seq(ref_seq), .last(last),
    .errors(errors), .waiting(waiting)
  );

  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic send(input logic [1:0] k, input logic [SLOT_W-1:0] c,
                      input logic [31:0] t, input logic [31:0] ivl, input logic h,
                      input logic [31:0] treq, input logic [31:0] sq);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    client      <= c;
    now         <= t;
    interval    <= ivl;
    header_ok   <= h;
    test_req_id <= treq;
    seq_num     <= sq;
    do @(posedge clk); while (!in_ready);
  endtask

  // mostly live sessions in a small pool, heartbeats often answering a recent tick
  task automatic send_random();
    int          r;
    logic [1:0]  k;
    logic [5:0]  c;
    logic [31:0] t;
    logic [31:0] ivl;
    logic [31:0] treq;
    r = $urandom_range(99);
    if (r < 15)      k = K_OPEN;
    else if (r < 65) k = K_BEAT;
    else if (r < 82) k = K_TICK;
    else             k = K_CLOSE;
    c = ($urandom_range(99) < 80) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
    cur_time = cur_time + $urandom_range(15);
    t   = ($urandom_range(99) < 5) ? $urandom : cur_time;
    ivl = ($urandom_range(99) < 5) ? $urandom : $urandom_range(60);
    treq = ($urandom_range(99) < 60) ? tick_hist[$urandom_range(3)] : $urandom;
    if (k == K_TICK) begin
      tick_hist[tick_wp] = t;
      tick_wp = (tick_wp + 1) % 4;
    end
    send(k, c, t, ivl, ($urandom_range(99) < 85), treq, $urandom);
  endtask

  initial begin
    #(5_000_000);
    $display("session_heartbeat_monitor_core: mismatch");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(K_BEAT, 6'd5, 32'd0, 32'd0, 1'b1, 32'd0, 32'd0);
    send(K_CLOSE, 6'd7, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0);
    send(K_TICK, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(K_OPEN, 6'd0, 32'd100, 32'd10, 1'b0, 32'd0, 32'd0);
    send(K_OPEN, 6'd63, 32'hFFFF_FFF0, 32'd32, 1'b0, 32'd0, 32'd0);
    send(K_OPEN, 6'd1, 32'd0, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0);
    send(K_OPEN, 6'd3, 32'd500, 32'd0, 1'b0, 32'd0, 32'd0);
    send(K_BEAT, 6'd0, 32'd105, 32'd0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(K_BEAT, 6'd0, 32'd105, 32'd0, 1'b1, 32'h1234, 32'h55);
    send(K_TICK, 6'd0, 32'd115, 32'd0, 1'b0, 32'd0, 32'd0);
    send(K_TICK, 6'd0, 32'd116, 32'd0, 1'b0, 32'd0, 32'd0);
    send(K_BEAT, 6'd0, 32'd117, 32'd0, 1'b1, 32'd5, 32'hA5A5_A5A5);
    send(K_BEAT, 6'd0, 32'd117, 32'd0, 1'b0, 32'd116, 32'd7);
    send(K_BEAT, 6'd0, 32'd118, 32'd0, 1'b1, 32'd116, 32'd9);
    send(K_BEAT, 6'd63, 32'd120, 32'd0, 1'b1, 32'd115, 32'd1);
    send(K_OPEN, 6'd0, 32'd130, 32'd5, 1'b0, 32'd0, 32'd0);
    send(K_TICK, 6'd0, 32'd400, 32'd0, 1'b0, 32'd0, 32'd0);
    send(K_TICK, 6'd0, 32'd500, 32'd0, 1'b0, 32'd0, 32'd0);
    send(K_BEAT, 6'd0, 32'd501, 32'd0, 1'b1, 32'd400, 32'd3);
    send(K_OPEN, 6'd2, 32'd600, 32'd3, 1'b0, 32'd0, 32'd0);
    send(K_CLOSE, 6'd2, 32'd601, 32'd0, 1'b0, 32'd0, 32'd0);
    send(K_BEAT, 6'd2, 32'd602, 32'd0, 1'b1, 32'd0, 32'd4);
    send(K_OPEN, 6'd4, 32'd700, 32'd0, 1'b0, 32'd0, 32'd0);
    send(K_TICK, 6'd0, 32'd700, 32'd0, 1'b0, 32'd0, 32'd0);
    send(K_TICK, 6'd0, 32'd701, 32'd0, 1'b0, 32'd0, 32'd0);

    cur_time = $urandom;
    for (int i = 0; i < 4; i++)
      tick_hist[i] = cur_time;

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 45; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      for (int n = 0; n < 75; n++)
        send_random();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    if (errors == 0)
      $display("session_heartbeat_monitor_core: match");
    else
      $display("session_heartbeat_monitor_core: mismatch");
    $finish;
  end

endmodule
